[hdl/tlq_pkg.sv]
// ----------------------------------------------------------------------------
// tlq_pkg
// Types and codes shared by the tagged load queue and its submodules.
// ----------------------------------------------------------------------------
package tlq_pkg;

  localparam int unsigned AddrWidth = 32;
  localparam int unsigned TagWidth  = 8;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    REQ_ADDR   = 2'd0,
    REQ_RETURN = 2'd1,
    REQ_DRAIN  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_ISSUE = 2'd2,
    STAT_NO_DONE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [AddrWidth-1:0] req_addr;
    logic [TagWidth-1:0]  req_tag;
    logic [DataWidth-1:0] mem_data;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic                 issue_valid;
    logic [AddrWidth-1:0] issue_addr;
    logic [TagWidth-1:0]  issue_tag;
    logic                 out_valid;
    logic [TagWidth-1:0]  out_tag;
    logic [DataWidth-1:0] out_data;
  } out_item_t;

  // Push and pop strobes of an index FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

[hdl/tlq_stream_if.sv]
// ----------------------------------------------------------------------------
// tlq_stream_if
// Valid/ready stream carrying one payload item per beat.
// ----------------------------------------------------------------------------
interface tlq_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[hdl/tlq_free_enc.sv]
// ----------------------------------------------------------------------------
// tlq_free_enc
// Priority encoder: finds the lowest-numbered entry that is not busy.
// ----------------------------------------------------------------------------
module tlq_free_enc #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic [DEPTH-1:0] busy_i,
  output logic             found_o,
  output logic [IdxW-1:0]  idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    // Scan from the top so the lowest free entry wins.
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!busy_i[i]) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end

endmodule

[hdl/tlq_idx_fifo.sv]
// ----------------------------------------------------------------------------
// tlq_idx_fifo
// Circular FIFO of entry numbers with head pointer and fill count.
// ----------------------------------------------------------------------------
module tlq_idx_fifo #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlq_pkg::fifo_ctl_t ctl_i,
  input  logic [IdxW-1:0]    push_idx_i,
  output logic [IdxW-1:0]    head_idx_o,
  output logic [IdxW-1:0]    next_idx_o,
  output logic [CntW-1:0]    count_o
);

  import tlq_pkg::*;

  logic [IdxW-1:0] slots_q [DEPTH];
  logic [IdxW-1:0] head_q, head_d, head_inc;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW:0]   tail_sum;
  logic [IdxW-1:0] tail;

  assign head_inc = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign tail_sum = (CntW + 1)'(head_q) + (CntW + 1)'(count_q);
  // Head plus count stays below twice the depth: one subtract wraps it.
  assign tail     = (tail_sum >= (CntW + 1)'(DEPTH)) ?
                    IdxW'(tail_sum - (CntW + 1)'(DEPTH)) : IdxW'(tail_sum);

  always_comb begin
    head_d  = ctl_i.pop ? head_inc : head_q;
    count_d = count_q + CntW'(ctl_i.push) - CntW'(ctl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      slots_q[tail] <= push_idx_i;
    end
  end

  assign head_idx_o = slots_q[head_q];
  assign next_idx_o = slots_q[head_inc];
  assign count_o    = count_q;

endmodule

[hdl/tagged_load_queue.sv]
// ----------------------------------------------------------------------------
// tagged_load_queue
// Load entry table with in-order issue and completion FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command per beat: a new load address with its tag, a
//   memory data return for the oldest issued load, or a drain of the oldest
//   completed load. out_o carries exactly one result beat per command: a
//   status code, the oldest issued load still waiting for memory (address
//   and tag, zero when none), and for a successful drain the drained tag
//   and data.
//   A command waits in the input register, then the table update and the
//   result register load happen in a single pass. Throughput is one command
//   per cycle while the receiver takes results; the table lookup (lowest
//   free entry encoder) and both index FIFOs update in that pass.
//   Reset empties the table and both FIFOs and drops any beat in flight.
//   When the receiver stalls, the result register holds its beat and the
//   input register takes one more command if it is empty; after that
//   in_i.ready falls until out_o is taken.
// ----------------------------------------------------------------------------
module tagged_load_queue #(
  parameter int unsigned TABLE_DEPTH = 8,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlq_stream_if.sink   in_i,
  tlq_stream_if.source out_o
);

  import tlq_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TagW = (TAG_BITS < TagWidth) ? TAG_BITS : TagWidth;

  // Input register
  logic     s_vld_q;
  in_item_t s_q;

  // Result register
  logic      o_vld_q;
  out_item_t o_q, o_d;

  logic advance;

  // Entry table: address/tag on the issue side, tag/data on the done side
  logic [AddrWidth-1:0] iss_addr_q [TABLE_DEPTH];
  logic [TagW-1:0]      iss_tag_q  [TABLE_DEPTH];
  logic [TagW-1:0]      dn_tag_q   [TABLE_DEPTH];
  logic [DataWidth-1:0] dn_data_q  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] busy_q;

  logic            free_found;
  logic [IdxW-1:0] free_idx;

  fifo_ctl_t       issue_ctl, done_ctl;
  logic [IdxW-1:0] issue_head, issue_next, done_head, done_next, new_head;
  logic [CntW-1:0] issue_cnt, done_cnt;

  logic    do_alloc, do_ret, do_drain;
  status_e status;
  logic    new_issue_valid;

  assign advance     = s_vld_q && (!o_vld_q || out_o.ready);
  assign in_i.ready  = !s_vld_q || advance;
  assign out_o.valid = o_vld_q;
  assign out_o.data  = o_q;

  tlq_free_enc #(.DEPTH(TABLE_DEPTH)) u_free_enc (
    .busy_i  (busy_q),
    .found_o (free_found),
    .idx_o   (free_idx)
  );

  tlq_idx_fifo #(.DEPTH(TABLE_DEPTH)) u_issue_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (issue_ctl),
    .push_idx_i (free_idx),
    .head_idx_o (issue_head),
    .next_idx_o (issue_next),
    .count_o    (issue_cnt)
  );

  tlq_idx_fifo #(.DEPTH(TABLE_DEPTH)) u_done_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (done_ctl),
    .push_idx_i (issue_head),
    .head_idx_o (done_head),
    .next_idx_o (done_next),
    .count_o    (done_cnt)
  );

  // Decode the command held in the input register.
  always_comb begin
    do_alloc = 1'b0;
    do_ret   = 1'b0;
    do_drain = 1'b0;
    status   = STAT_DONE;
    case (s_q.req_type)
      REQ_ADDR: begin
        if (free_found) do_alloc = 1'b1;
        else            status   = STAT_FULL;
      end
      REQ_RETURN: begin
        if (issue_cnt != '0) do_ret = 1'b1;
        else                 status = STAT_NO_ISSUE;
      end
      REQ_DRAIN: begin
        if (done_cnt != '0) do_drain = 1'b1;
        else                status   = STAT_NO_DONE;
      end
      default: status = STAT_DONE;
    endcase
  end

  always_comb begin
    issue_ctl.push = advance && do_alloc;
    issue_ctl.pop  = advance && do_ret;
    done_ctl.push  = advance && do_ret;
    done_ctl.pop   = advance && do_drain;
  end

  // Issue head as it stands after this step.
  assign new_head = do_ret ? issue_next : issue_head;

  always_comb begin
    o_d        = '0;
    o_d.status = status;
    if (do_alloc) new_issue_valid = 1'b1;
    else if (do_ret) new_issue_valid = (issue_cnt > CntW'(1));
    else new_issue_valid = (issue_cnt != '0);
    o_d.issue_valid = new_issue_valid;
    if (do_alloc && issue_cnt == '0) begin
      o_d.issue_addr = s_q.req_addr;
      o_d.issue_tag  = TagWidth'(s_q.req_tag[TagW-1:0]);
    end else if (new_issue_valid) begin
      o_d.issue_addr = iss_addr_q[new_head];
      o_d.issue_tag  = TagWidth'(iss_tag_q[new_head]);
    end
    if (do_drain) begin
      o_d.out_valid = 1'b1;
      o_d.out_tag   = TagWidth'(dn_tag_q[done_head]);
      o_d.out_data  = dn_data_q[done_head];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      if (in_i.ready) s_vld_q <= in_i.valid;
      if (advance) o_vld_q <= 1'b1;
      else if (out_o.ready) o_vld_q <= 1'b0;
      if (advance && do_alloc) busy_q[free_idx] <= 1'b1;
      if (advance && do_drain) busy_q[done_head] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) s_q <= in_i.data;
    if (advance) o_q <= o_d;
    if (advance && do_alloc) begin
      iss_addr_q[free_idx] <= s_q.req_addr;
      iss_tag_q[free_idx]  <= s_q.req_tag[TagW-1:0];
    end
    // The result register already shows the current issue head's tag.
    if (advance && do_ret) begin
      dn_tag_q[issue_head]  <= o_q.issue_tag[TagW-1:0];
      dn_data_q[issue_head] <= s_q.mem_data;
    end
  end

  // Every busy entry sits in exactly one of the two FIFOs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == (32'(issue_cnt) + 32'(done_cnt)))
    else $error("busy entries and FIFO counts disagree");

  // A drained load always reports a clean status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_q.out_valid |-> o_q.status == STAT_DONE)
    else $error("drained load with nonzero status");

  // With an empty result register the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !o_vld_q |-> in_i.ready)
    else $error("input stalled while result register empty");

  // A drain pops the completion FIFO exactly once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_ctl.pop && !done_ctl.push |=> done_cnt == $past(done_cnt) - CntW'(1))
    else $error("completion count did not drop on drain");

  // After a drain the next completed entry moves up to the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_ctl.pop && done_cnt > CntW'(1) |=> done_head == $past(done_next))
    else $error("completion head did not advance in order");

endmodule

[dv/load_queue_checker.sv]
// ----------------------------------------------------------------------------
// load_queue_checker
// Watches the command and result channels of the tagged load queue, keeps
// its own copy of the entry table and both index FIFOs, works out the
// result beat owed for every accepted command and compares each result
// beat field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module load_queue_checker #(
  parameter int unsigned TABLE_DEPTH = 8,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  logic               cmd_ready_i,
  input  tlq_pkg::in_item_t  cmd_data_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  tlq_pkg::out_item_t res_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        owed_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import tlq_pkg::*;

  localparam logic [TagWidth-1:0] TagMask = TagWidth'((64'd1 << TAG_BITS) - 64'd1);

  logic [AddrWidth-1:0] slot_addr [TABLE_DEPTH];
  logic [TagWidth-1:0]  slot_tag  [TABLE_DEPTH];
  logic [DataWidth-1:0] slot_data [TABLE_DEPTH];
  logic                 slot_busy [TABLE_DEPTH];
  int                   issue_q   [TABLE_DEPTH];
  int                   done_q    [TABLE_DEPTH];
  int                   issue_rd;
  int                   issue_cnt;
  int                   done_rd;
  int                   done_cnt;

  out_item_t   owed_results[$];
  int unsigned err_count;
  int unsigned result_idx;

  task automatic clear_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_addr[i] = '0;
      slot_tag[i]  = '0;
      slot_data[i] = '0;
      slot_busy[i] = 1'b0;
      issue_q[i]   = 0;
      done_q[i]    = 0;
    end
    issue_rd  = 0;
    issue_cnt = 0;
    done_rd   = 0;
    done_cnt  = 0;
  endtask

  // Update the table for one command and build the result beat it owes.
  task automatic apply_command(input in_item_t cmd, output out_item_t res);
    int slot;
    int head;
    slot = -1;
    res  = '0;
    res.status = STAT_DONE;
    case (cmd.req_type)
      REQ_ADDR: begin
        // lowest free entry wins
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
          if (!slot_busy[i]) slot = i;
        end
        if (slot < 0 || issue_cnt >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          slot_addr[slot] = cmd.req_addr;
          slot_tag[slot]  = cmd.req_tag & TagMask;
          slot_data[slot] = '0;
          slot_busy[slot] = 1'b1;
          issue_q[(issue_rd + issue_cnt) % TABLE_DEPTH] = slot;
          issue_cnt++;
        end
      end
      REQ_RETURN: begin
        if (issue_cnt == 0 || done_cnt >= TABLE_DEPTH) begin
          res.status = STAT_NO_ISSUE;
        end else begin
          slot = issue_q[issue_rd];
          slot_data[slot] = cmd.mem_data;
          issue_rd = (issue_rd + 1) % TABLE_DEPTH;
          issue_cnt--;
          done_q[(done_rd + done_cnt) % TABLE_DEPTH] = slot;
          done_cnt++;
        end
      end
      REQ_DRAIN: begin
        if (done_cnt == 0) begin
          res.status = STAT_NO_DONE;
        end else begin
          slot = done_q[done_rd];
          res.out_valid = 1'b1;
          res.out_tag   = slot_tag[slot];
          res.out_data  = slot_data[slot];
          slot_addr[slot] = '0;
          slot_tag[slot]  = '0;
          slot_data[slot] = '0;
          slot_busy[slot] = 1'b0;
          done_rd = (done_rd + 1) % TABLE_DEPTH;
          done_cnt--;
        end
      end
      default: begin
      end
    endcase
    // the issue view reflects the table after the update
    if (issue_cnt != 0) begin
      head = issue_q[issue_rd];
      res.issue_valid = 1'b1;
      res.issue_addr  = slot_addr[head];
      res.issue_tag   = slot_tag[head];
    end
  endtask

  task automatic report(input string msg);
    $display("[%0t] result %0d: %s", $realtime, result_idx, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  initial begin
    err_count  = 0;
    result_idx = 0;
    clear_table();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t owed;
    out_item_t fresh;
    if (!rst_ni) begin
      clear_table();
      owed_results.delete();
      owed_count_o <= 0;
      fail_count_o <= err_count;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (owed_results.size() == 0) begin
          report("result beat with nothing owed");
        end else begin
          owed = owed_results[0];
          owed_results.delete(0);
          check_field("status", 32'(res_data_i.status), 32'(owed.status));
          check_field("issue_valid", 32'(res_data_i.issue_valid), 32'(owed.issue_valid));
          check_field("issue_addr", res_data_i.issue_addr, owed.issue_addr);
          check_field("issue_tag", 32'(res_data_i.issue_tag), 32'(owed.issue_tag));
          check_field("out_valid", 32'(res_data_i.out_valid), 32'(owed.out_valid));
          check_field("out_tag", 32'(res_data_i.out_tag), 32'(owed.out_tag));
          check_field("out_data", res_data_i.out_data, owed.out_data);
        end
        result_idx++;
      end
      if (cmd_valid_i && cmd_ready_i) begin
        apply_command(cmd_data_i, fresh);
        owed_results = {owed_results, fresh};
      end
      owed_count_o <= owed_results.size();
      fail_count_o <= err_count;
    end
  end

endmodule

[dv/tb_tagged_load_queue.sv]
// ----------------------------------------------------------------------------
// tb_tagged_load_queue
// Drives commands into the tagged load queue and takes its results with
// random gaps and stalls on both sides: a directed opening covering empty,
// full and unused-command cases, then phases of random traffic biased to
// fill, to drain or to stay balanced, some with no gaps, plus one long
// receiver hold-off that backs the block up. The checker beside the block
// judges every beat.
module tb_tagged_load_queue;

  timeunit 1ns;
  timeprecision 1ps;

  import tlq_pkg::*;

  localparam int unsigned TableDepth  = 8;
  localparam int unsigned TagBits     = 8;
  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned RandomCmds  = 1350;
  localparam int unsigned PhaseLen    = 40;
  localparam int unsigned HoldStart   = 400;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned CycleLimit  = 400_000;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN,
    MIX_BURST
  } traffic_mix_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt;
  logic        no_idle;
  int unsigned fail_count;
  int unsigned owed_count;

  tlq_stream_if #(.T(in_item_t))  cmd_if ();
  tlq_stream_if #(.T(out_item_t)) res_if ();

  tagged_load_queue #(
    .TABLE_DEPTH(TableDepth),
    .TAG_BITS   (TagBits)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  load_queue_checker #(
    .TABLE_DEPTH(TableDepth),
    .TAG_BITS   (TagBits)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_if.valid),
    .cmd_ready_i (cmd_if.ready),
    .cmd_data_i  (cmd_if.data),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_data_i  (res_if.data),
    .fail_count_o(fail_count),
    .owed_count_o(owed_count)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2.0) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_cmd(input logic [1:0] kind,
                                        input logic [AddrWidth-1:0] addr,
                                        input logic [TagWidth-1:0] tag,
                                        input logic [DataWidth-1:0] data);
    in_item_t cmd;
    cmd.req_type = kind;
    cmd.req_addr = addr;
    cmd.req_tag  = tag;
    cmd.mem_data = data;
    return cmd;
  endfunction

  function automatic in_item_t random_cmd(input traffic_mix_e mix);
    int unsigned p_addr;
    int unsigned p_ret;
    int unsigned pick;
    logic [1:0]  kind;
    case (mix)
      MIX_FILL:  begin p_addr = 60; p_ret = 25; end
      MIX_DRAIN: begin p_addr = 15; p_ret = 35; end
      default:   begin p_addr = 35; p_ret = 32; end
    endcase
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) kind = REQ_UNUSED;
    else if (pick < p_addr)        kind = REQ_ADDR;
    else if (pick < p_addr + p_ret) kind = REQ_RETURN;
    else                           kind = REQ_DRAIN;
    return make_cmd(kind, $urandom(), TagWidth'($urandom()), $urandom());
  endfunction

  // Call at a rising edge; returns once the beat is taken and any idle gap after it is over.
  task automatic send_cmd(input in_item_t cmd);
    int unsigned gap;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= cmd;
    do @(posedge clk_i); while (!cmd_if.ready);
    sent_cnt++;
    gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : result_sink
    logic held;
    held = 1'b0;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && sent_cnt >= HoldStart) begin
        // back the block up while commands keep coming
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
    end
  end

  initial begin : command_source
    in_item_t     cmd;
    traffic_mix_e mix;
    int unsigned  done_cmds;
    int unsigned  phase_left;
    sent_cnt     = 0;
    no_idle      = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    rst_ni       = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: nothing completed, nothing issued, unused code
    send_cmd(make_cmd(REQ_DRAIN, '0, '0, '0));
    send_cmd(make_cmd(REQ_RETURN, '1, '1, '1));
    send_cmd(make_cmd(REQ_UNUSED, '1, '1, '1));
    // fill every entry, extremes first, then overflow
    send_cmd(make_cmd(REQ_ADDR, '0, '0, '1));
    send_cmd(make_cmd(REQ_ADDR, '1, '1, '0));
    for (int i = 0; i < TableDepth - 2; i++) begin
      send_cmd(make_cmd(REQ_ADDR, $urandom(), TagWidth'($urandom()), $urandom()));
    end
    send_cmd(make_cmd(REQ_ADDR, 32'hA5A5_5A5A, 8'h5A, '0));
    send_cmd(make_cmd(REQ_RETURN, '0, '0, '1));
    send_cmd(make_cmd(REQ_RETURN, '1, '1, '0));
    send_cmd(make_cmd(REQ_DRAIN, '1, '1, '1));
    send_cmd(make_cmd(REQ_DRAIN, '0, '0, '0));
    // completions gone while loads are still issued
    send_cmd(make_cmd(REQ_DRAIN, '0, '0, '0));
    // freed entries are reused lowest first
    send_cmd(make_cmd(REQ_ADDR, 32'h0000_1000, 8'h01, '0));
    send_cmd(make_cmd(REQ_ADDR, 32'hFFFF_F000, 8'hFE, '0));
    send_cmd(make_cmd(REQ_UNUSED, $urandom(), TagWidth'($urandom()), $urandom()));

    done_cmds  = 0;
    phase_left = 0;
    mix        = MIX_EVEN;
    while (done_cmds < RandomCmds) begin
      if (phase_left == 0) begin
        mix        = traffic_mix_e'($urandom_range(0, 3));
        no_idle    = (mix == MIX_BURST);
        phase_left = PhaseLen;
      end
      cmd = random_cmd(mix);
      send_cmd(cmd);
      if (cmd.req_type != REQ_UNUSED) begin
        done_cmds++;
        phase_left--;
      end
    end
    no_idle = 1'b0;

    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[tagged_load_queue.f]
hdl/tlq_pkg.sv
hdl/tlq_stream_if.sv
hdl/tlq_free_enc.sv
hdl/tlq_idx_fifo.sv
hdl/tagged_load_queue.sv
dv/load_queue_checker.sv
dv/tb_tagged_load_queue.sv
